FILE: design/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared widths, constants and the arctangent table of the trajectory step
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int COORD_BITS    = 32;
  localparam int FRACTION_BITS = 16;

  localparam int IN_ANGLE_W  = 16;
  localparam int LENGTH_W    = 24;
  localparam int OUT_COORD_W = 32;
  localparam int OUT_ANGLE_W = 16;

  // cordic datapath
  localparam int TURN_W       = 32;
  localparam int CORDIC_W     = 33;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INIT = 33'sd652032874;

  // multiplier datapath, products rounded from q2.30 trig values
  localparam int MUL_V_W     = 28;
  localparam int MUL_T_W     = 32;
  localparam int MUL_P_W     = MUL_V_W + MUL_T_W;
  localparam int MUL_FRAC    = 30;

  localparam int SUM_W = (COORD_BITS > MUL_V_W) ? COORD_BITS + 1 : MUL_V_W + 1;

  typedef struct packed {
    logic signed [MUL_T_W-1:0] cos_v;
    logic signed [MUL_T_W-1:0] sin_v;
  } tsr_trig_t;

  function automatic logic [TURN_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [TURN_W-1:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/trajectory_segment_rotate_step.sv
// ----------------------------------------------------------------------------
// trajectory_segment_rotate_step
// One scattering step of an electron trajectory: rotate and add a segment
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes a deflection angle, an azimuth
// step, a step length and a restart flag. The result channel
// (out_valid/out_ready) returns the new point, both frame angles after the
// step and a flag that is set when a coordinate was clamped.
// One item is worked on at a time. After a transfer in, one cordic unit with
// 24 micro-rotations runs four times (theta, phi, tilt, heading) and a
// two-stage multiplier is used twelve times. The state machine then returns
// to idle, raising in_ready, with the same edge that loads the result
// register, so no new item is taken before the last one's result is loaded.
// The result sits in an output register: the next item is taken while it
// waits, and only the final update of a following item waits for out_ready.
// Synchronous reset clears the point and both angles to zero and drops
// out_valid. A restart flag clears them before its own step.
// ----------------------------------------------------------------------------
module trajectory_segment_rotate_step (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [tsr_pkg::IN_ANGLE_W-1:0]   in_deflection_angle,
  input  logic signed [tsr_pkg::IN_ANGLE_W-1:0]   in_azimuth_step,
  input  logic        [tsr_pkg::LENGTH_W-1:0]     in_step_length,
  input  logic                                    in_restart,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [tsr_pkg::OUT_COORD_W-1:0]  out_pos_x,
  output logic signed [tsr_pkg::OUT_COORD_W-1:0]  out_pos_y,
  output logic signed [tsr_pkg::OUT_COORD_W-1:0]  out_pos_z,
  output logic        [tsr_pkg::OUT_ANGLE_W-1:0]  out_tilt_out,
  output logic        [tsr_pkg::OUT_ANGLE_W-1:0]  out_heading_out,
  output logic                                    out_saturated
);

  localparam int AB = tsr_pkg::ANGLE_BITS;
  localparam int CB = tsr_pkg::COORD_BITS;
  localparam int VW = tsr_pkg::MUL_V_W;
  localparam int SM = tsr_pkg::SUM_W;

  localparam logic signed [SM-1:0] CMAX = {{(SM - CB + 1){1'b0}}, {(CB - 1){1'b1}}};
  localparam logic signed [SM-1:0] CMIN = ~CMAX;

  typedef enum logic [2:0] {
    S_IDLE, S_TRIG_GO, S_TRIG_WAIT, S_MUL_GO, S_MUL_WAIT, S_UPD
  } state_t;

  typedef enum logic [3:0] {
    OP_RS, OP_YN, OP_XN, OP_ZN, OP_XR_A, OP_XR_B,
    OP_YR_A, OP_YR_B, OP_DX_A, OP_DX_B, OP_DZ_A, OP_DZ_B
  } op_t;

  function automatic logic [CB:0] sat_coord(input logic signed [SM-1:0] v);
    logic [CB:0] r;
    if (v > CMAX) begin
      r = {1'b1, CB'(CMAX)};
    end else if (v < CMIN) begin
      r = {1'b1, CB'(CMIN)};
    end else begin
      r = {1'b0, CB'(v)};
    end
    return r;
  endfunction

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic [1:0] tidx_r, tidx_nxt;

  logic [AB-1:0] theta_r, theta_nxt, phi_r, phi_nxt;
  logic [AB-1:0] tilt_r, tilt_nxt, head_r, head_nxt;
  logic [tsr_pkg::LENGTH_W-1:0] len_r, len_nxt;
  logic signed [CB-1:0] px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;

  tsr_pkg::tsr_trig_t trig_r [4];
  tsr_pkg::tsr_trig_t trig_nxt [4];

  logic signed [VW-1:0] rs_r, rs_nxt, xn_r, xn_nxt, yn_r, yn_nxt, zn_r, zn_nxt;
  logic signed [VW-1:0] xr_r, xr_nxt, yr_r, yr_nxt, dx_r, dx_nxt, dz_r, dz_nxt;
  logic signed [VW-1:0] tmp_r, tmp_nxt;

  logic                                 ov_r, ov_nxt;
  logic signed [tsr_pkg::OUT_COORD_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic [tsr_pkg::OUT_ANGLE_W-1:0]      ot_r, ot_nxt, oh_r, oh_nxt;
  logic                                 osat_r, osat_nxt;

  logic                  cordic_start, cordic_done;
  logic [AB-1:0]         cordic_angle;
  tsr_pkg::tsr_trig_t    cordic_res;
  logic                  mul_start, mul_done;
  logic signed [VW-1:0]  mul_v, mul_res;
  logic signed [tsr_pkg::MUL_T_W-1:0] mul_t;

  logic [CB:0] sx, sy, sz;
  logic        out_free;

  tsr_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cordic_start),
    .angle  (cordic_angle),
    .done   (cordic_done),
    .result (cordic_res)
  );

  tsr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .v     (mul_v),
    .t     (mul_t),
    .done  (mul_done),
    .res   (mul_res)
  );

  // operand select for the shared cordic unit and multiplier, start strobes and in_ready
  always_comb begin
    case (tidx_r)
      2'd0:    cordic_angle = theta_r;
      2'd1:    cordic_angle = phi_r;
      2'd2:    cordic_angle = tilt_r;
      default: cordic_angle = head_r;
    endcase
    case (op_r)
      OP_RS:   begin mul_v = VW'(signed'({1'b0, len_r})); mul_t = trig_r[0].sin_v; end
      OP_YN:   begin mul_v = VW'(signed'({1'b0, len_r})); mul_t = trig_r[0].cos_v; end
      OP_XN:   begin mul_v = rs_r; mul_t = trig_r[1].cos_v; end
      OP_ZN:   begin mul_v = rs_r; mul_t = trig_r[1].sin_v; end
      OP_XR_A: begin mul_v = xn_r; mul_t = trig_r[2].cos_v; end
      OP_XR_B: begin mul_v = yn_r; mul_t = trig_r[2].sin_v; end
      OP_YR_A: begin mul_v = xn_r; mul_t = trig_r[2].sin_v; end
      OP_YR_B: begin mul_v = yn_r; mul_t = trig_r[2].cos_v; end
      OP_DX_A: begin mul_v = xr_r; mul_t = trig_r[3].cos_v; end
      OP_DX_B: begin mul_v = zn_r; mul_t = trig_r[3].sin_v; end
      OP_DZ_A: begin mul_v = zn_r; mul_t = trig_r[3].cos_v; end
      default: begin mul_v = xr_r; mul_t = trig_r[3].sin_v; end
    endcase
    cordic_start = (state_r == S_TRIG_GO);
    mul_start    = (state_r == S_MUL_GO);
    in_ready     = (state_r == S_IDLE);
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    tidx_nxt  = tidx_r;
    theta_nxt = theta_r;
    phi_nxt   = phi_r;
    tilt_nxt  = tilt_r;
    head_nxt  = head_r;
    len_nxt   = len_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    pz_nxt    = pz_r;
    trig_nxt  = trig_r;
    rs_nxt    = rs_r;
    xn_nxt    = xn_r;
    yn_nxt    = yn_r;
    zn_nxt    = zn_r;
    xr_nxt    = xr_r;
    yr_nxt    = yr_r;
    dx_nxt    = dx_r;
    dz_nxt    = dz_r;
    tmp_nxt   = tmp_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    oz_nxt    = oz_r;
    ot_nxt    = ot_r;
    oh_nxt    = oh_r;
    osat_nxt  = osat_r;

    out_free = !ov_r || out_ready;
    ov_nxt   = ov_r && !out_ready;

    sx = sat_coord(SM'(px_r) + SM'(dx_r));
    sy = sat_coord(SM'(py_r) + SM'(yr_r));
    sz = sat_coord(SM'(pz_r) + SM'(dz_r));

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          theta_nxt = AB'(in_deflection_angle);
          phi_nxt   = AB'(in_azimuth_step);
          len_nxt   = in_step_length;
          if (in_restart) begin
            px_nxt   = '0;
            py_nxt   = '0;
            pz_nxt   = '0;
            tilt_nxt = '0;
            head_nxt = '0;
          end
          tidx_nxt  = '0;
          state_nxt = S_TRIG_GO;
        end
      end
      S_TRIG_GO: begin
        state_nxt = S_TRIG_WAIT;
      end
      S_TRIG_WAIT: begin
        if (cordic_done) begin
          trig_nxt[tidx_r] = cordic_res;
          tidx_nxt = tidx_r + 1'b1;
          if (tidx_r == 2'd3) begin
            op_nxt    = OP_RS;
            state_nxt = S_MUL_GO;
          end else begin
            state_nxt = S_TRIG_GO;
          end
        end
      end
      S_MUL_GO: begin
        state_nxt = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (mul_done) begin
          case (op_r)
            OP_RS:   rs_nxt = mul_res;
            OP_YN:   yn_nxt = -mul_res;
            OP_XN:   xn_nxt = mul_res;
            OP_ZN:   zn_nxt = mul_res;
            OP_XR_B: xr_nxt = tmp_r - mul_res;
            OP_YR_B: yr_nxt = tmp_r + mul_res;
            OP_DX_B: dx_nxt = tmp_r + mul_res;
            OP_DZ_B: dz_nxt = tmp_r - mul_res;
            default: tmp_nxt = mul_res;
          endcase
          if (op_r == OP_DZ_B) begin
            state_nxt = S_UPD;
          end else begin
            op_nxt    = op_t'(op_r + 1'b1);
            state_nxt = S_MUL_GO;
          end
        end
      end
      S_UPD: begin
        if (out_free) begin
          px_nxt    = signed'(sx[CB-1:0]);
          py_nxt    = signed'(sy[CB-1:0]);
          pz_nxt    = signed'(sz[CB-1:0]);
          tilt_nxt  = tilt_r + theta_r;
          head_nxt  = head_r + phi_r;
          ox_nxt    = tsr_pkg::OUT_COORD_W'(signed'(sx[CB-1:0]));
          oy_nxt    = tsr_pkg::OUT_COORD_W'(signed'(sy[CB-1:0]));
          oz_nxt    = tsr_pkg::OUT_COORD_W'(signed'(sz[CB-1:0]));
          ot_nxt    = tsr_pkg::OUT_ANGLE_W'(tilt_r + theta_r);
          oh_nxt    = tsr_pkg::OUT_ANGLE_W'(head_r + phi_r);
          osat_nxt  = sx[CB] | sy[CB] | sz[CB];
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_RS;
      tidx_r  <= '0;
      ov_r    <= 1'b0;
      px_r    <= '0;
      py_r    <= '0;
      pz_r    <= '0;
      tilt_r  <= '0;
      head_r  <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      tidx_r  <= tidx_nxt;
      ov_r    <= ov_nxt;
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      pz_r    <= pz_nxt;
      tilt_r  <= tilt_nxt;
      head_r  <= head_nxt;
    end
    theta_r <= theta_nxt;
    phi_r   <= phi_nxt;
    len_r   <= len_nxt;
    trig_r  <= trig_nxt;
    rs_r    <= rs_nxt;
    xn_r    <= xn_nxt;
    yn_r    <= yn_nxt;
    zn_r    <= zn_nxt;
    xr_r    <= xr_nxt;
    yr_r    <= yr_nxt;
    dx_r    <= dx_nxt;
    dz_r    <= dz_nxt;
    tmp_r   <= tmp_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    oz_r    <= oz_nxt;
    ot_r    <= ot_nxt;
    oh_r    <= oh_nxt;
    osat_r  <= osat_nxt;
  end

  assign out_valid       = ov_r;
  assign out_pos_x       = ox_r;
  assign out_pos_y       = oy_r;
  assign out_pos_z       = oz_r;
  assign out_tilt_out    = ot_r;
  assign out_heading_out = oh_r;
  assign out_saturated   = osat_r;

  a_cordic_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_done |-> state_r == S_TRIG_WAIT)
    else $error("cordic result outside its wait state");

  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_MUL_WAIT)
    else $error("multiplier result outside its wait state");

  a_update_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && (!ov_r || out_ready)) |=> (ov_r && state_r == S_IDLE))
    else $error("final update did not load the result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r)
    else $error("pending result dropped without transfer");

endmodule

FILE: design/tsr_cordic.sv
// ----------------------------------------------------------------------------
// tsr_cordic
// Iterative rotation-mode cordic, one micro-rotation per cycle, cos and sin
// ----------------------------------------------------------------------------
module tsr_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tsr_pkg::ANGLE_BITS-1:0] angle,
  output logic                          done,
  output tsr_pkg::tsr_trig_t            result
);

  localparam int TW = tsr_pkg::TURN_W;
  localparam int CW = tsr_pkg::CORDIC_W;
  localparam int SW = tsr_pkg::STEP_W;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [SW-1:0]        step_r, step_nxt;
  logic [1:0]           quad_r, quad_nxt;
  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  tsr_pkg::tsr_trig_t   res_r, res_nxt;

  logic [TW-1:0]        turn, rounded, resid;
  logic signed [CW-1:0] xs, ys, xi, yi, zi, atan_v;

  always_comb begin
    turn    = {angle, {(TW - tsr_pkg::ANGLE_BITS){1'b0}}};
    rounded = turn + {2'b00, 1'b1, {(TW - 3){1'b0}}};
    resid   = turn - {rounded[TW-1:TW-2], {(TW - 2){1'b0}}};

    xs     = x_r >>> step_r;
    ys     = y_r >>> step_r;
    atan_v = signed'({1'b0, tsr_pkg::atan_turn(step_r)});
    if (!z_r[CW-1]) begin
      xi = x_r - ys;
      yi = y_r + xs;
      zi = z_r - atan_v;
    end else begin
      xi = x_r + ys;
      yi = y_r - xs;
      zi = z_r + atan_v;
    end

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quad_nxt = quad_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    res_nxt  = res_r;

    if (busy_r) begin
      x_nxt    = xi;
      y_nxt    = yi;
      z_nxt    = zi;
      step_nxt = step_r + 1'b1;
      if (step_r == SW'(tsr_pkg::CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        case (quad_r)
          2'd0: begin
            res_nxt.cos_v = tsr_pkg::MUL_T_W'(xi);
            res_nxt.sin_v = tsr_pkg::MUL_T_W'(yi);
          end
          2'd1: begin
            res_nxt.cos_v = tsr_pkg::MUL_T_W'(-yi);
            res_nxt.sin_v = tsr_pkg::MUL_T_W'(xi);
          end
          2'd2: begin
            res_nxt.cos_v = tsr_pkg::MUL_T_W'(-xi);
            res_nxt.sin_v = tsr_pkg::MUL_T_W'(-yi);
          end
          default: begin
            res_nxt.cos_v = tsr_pkg::MUL_T_W'(yi);
            res_nxt.sin_v = tsr_pkg::MUL_T_W'(-xi);
          end
        endcase
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quad_nxt = rounded[TW-1:TW-2];
      x_nxt    = tsr_pkg::CORDIC_GAIN_INIT;
      y_nxt    = '0;
      z_nxt    = signed'({resid[TW-1], resid});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    quad_r <= quad_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    res_r  <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

FILE: design/tsr_mul.sv
// ----------------------------------------------------------------------------
// tsr_mul
// Two-stage multiplier, value times q2.30 trig factor with rounding
// ----------------------------------------------------------------------------
module tsr_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [tsr_pkg::MUL_V_W-1:0] v,
  input  logic signed [tsr_pkg::MUL_T_W-1:0] t,
  output logic                               done,
  output logic signed [tsr_pkg::MUL_V_W-1:0] res
);

  localparam int PW = tsr_pkg::MUL_P_W;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (tsr_pkg::MUL_FRAC - 1);

  logic                               v1_r, v2_r;
  logic signed [PW-1:0]               prod_r;
  logic signed [PW-1:0]               rnd;
  logic signed [tsr_pkg::MUL_V_W-1:0] res_r;

  always_comb begin
    rnd = prod_r + HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
    prod_r <= PW'(v) * PW'(t);
    res_r  <= tsr_pkg::MUL_V_W'(rnd >>> tsr_pkg::MUL_FRAC);
  end

  assign done = v2_r;
  assign res  = res_r;

endmodule
